>>> rtl/pcsd_pkg.sv
package pcsd_pkg;

   localparam int MAX_PIXELS_DEF = 524288;

   localparam int HUE_W     = 8;
   localparam int SCORE_W   = 8;
   localparam int PHASE_W   = 3;
   localparam int HOLD_W    = 8;
   localparam int MISS_W    = 2;
   localparam int PERIOD_W  = 8;
   localparam int FRAME_W   = 20;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   // register map, decoded on paddr[2]
   localparam logic CSR_PERIOD       = 1'b0;
   localparam logic CSR_FRAME_PIXELS = 1'b1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET       = 8'd5;
   localparam logic [FRAME_W-1:0]  FRAME_PIXELS_RESET = 20'd307200;

   // sequence phases
   localparam logic [PHASE_W-1:0] PHASE_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_RED    = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_GREEN  = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_BLUE   = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_YELLOW = 3'd4;

   // hue class bounds
   localparam logic [HUE_W-1:0] HUE_RED_LO    = 8'd150;
   localparam logic [HUE_W-1:0] HUE_RED_HI    = 8'd10;
   localparam logic [HUE_W-1:0] HUE_GREEN_LO  = 8'd70;
   localparam logic [HUE_W-1:0] HUE_GREEN_HI  = 8'd95;
   localparam logic [HUE_W-1:0] HUE_BLUE_HI   = 8'd125;
   localparam logic [HUE_W-1:0] HUE_YELLOW_LO = 8'd10;
   localparam logic [HUE_W-1:0] HUE_YELLOW_HI = 8'd80;

   localparam logic [SCORE_W-1:0] SCORE_FULL = 8'd200;

   typedef struct packed {
      logic [SCORE_W-1:0] pixel_score;
      logic [MISS_W-1:0]  miss_count;
      logic [HOLD_W-1:0]  hold_count;
      logic [PHASE_W-1:0] color_state;
   } pixel_state_type;

   localparam int STATE_W = $bits(pixel_state_type);

   function automatic logic hue_in_class(input logic [PHASE_W-1:0] phase,
                                         input logic [HUE_W-1:0] hue);
      logic hit;
      hit = 1'b0;
      case (phase)
         PHASE_RED:    hit = (hue >= HUE_RED_LO) || (hue < HUE_RED_HI);
         PHASE_GREEN:  hit = (hue >= HUE_GREEN_LO) && (hue < HUE_GREEN_HI);
         PHASE_BLUE:   hit = (hue >= HUE_GREEN_HI) && (hue < HUE_BLUE_HI);
         PHASE_YELLOW: hit = (hue >= HUE_YELLOW_LO) && (hue < HUE_YELLOW_HI);
         default:      hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

>>> rtl/pixel_color_sequence_detector.sv
// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tdata[7:0] hue
// rsp       out  rsp_tvalid/tready    tdata[7:0] score, [10:8] seq_state; tlast frame_end
// csr       in   psel/penable/pwrite  0x0 period, 0x4 frame_pixels
//
// one pixel per cycle sustained while rsp is not stalled; a result passes the position
// register, the state ram read and the update into the output register.
// all stages hold together while rsp is stalled; req_tready drops only then.
// per-pixel state reads as zero until first written, tracked by a fill count,
// so there is no clearing pass after reset.
// reset is synchronous; it clears valids, position, fill count and resets the csr registers.
module pixel_color_sequence_detector #(
   parameter int MAX_PIXELS = pcsd_pkg::MAX_PIXELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // hue [7:0]
   input  logic [7:0]  req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // score [7:0], seq_state [10:8], zero [15:11]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [pcsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pcsd_pkg::CSR_W-1:0]      csr_pwdata,
   output logic [pcsd_pkg::CSR_W-1:0]      csr_prdata,
   output logic        csr_pready
);

   localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int LIM_W = (CNT_W > pcsd_pkg::FRAME_W) ? CNT_W : pcsd_pkg::FRAME_W;

   // configuration
   logic [pcsd_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [pcsd_pkg::FRAME_W-1:0]  frame_pixels_ff, frame_pixels_in;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      period_in       = period_ff;
      frame_pixels_in = frame_pixels_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            pcsd_pkg::CSR_PERIOD:       period_in = csr_pwdata[pcsd_pkg::PERIOD_W-1:0];
            pcsd_pkg::CSR_FRAME_PIXELS: frame_pixels_in = csr_pwdata[pcsd_pkg::FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         pcsd_pkg::CSR_PERIOD:
            csr_prdata = {{(pcsd_pkg::CSR_W-pcsd_pkg::PERIOD_W){1'b0}}, period_ff};
         pcsd_pkg::CSR_FRAME_PIXELS:
            csr_prdata = {{(pcsd_pkg::CSR_W-pcsd_pkg::FRAME_W){1'b0}}, frame_pixels_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= pcsd_pkg::PERIOD_RESET;
         frame_pixels_ff <= pcsd_pkg::FRAME_PIXELS_RESET;
      end else begin
         period_ff       <= period_in;
         frame_pixels_ff <= frame_pixels_in;
      end
   end

   // pipeline control: every stage moves together
   logic rsp_valid_ff;
   logic advance;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   logic req_take;
   assign req_take = req_tvalid && req_tready;

   // stage 0: frame position
   logic [POS_W-1:0] pixel_position_ff, pixel_position_in;
   logic [LIM_W-1:0] frame_ext, limit, pos_ext, pos_next;
   logic [POS_W-1:0] pos_clamped;
   logic             pos_last;

   always_comb begin
      frame_ext = LIM_W'(frame_pixels_ff);
      if (frame_ext == '0) begin
         limit = LIM_W'(1);
      end else if (frame_ext > LIM_W'(MAX_PIXELS)) begin
         limit = LIM_W'(MAX_PIXELS);
      end else begin
         limit = frame_ext;
      end
      pos_ext  = LIM_W'(pixel_position_ff);
      pos_next = pos_ext + LIM_W'(1);
      // a frame shrunk mid-frame folds the position onto its last pixel
      if (pos_ext >= limit) begin
         pos_clamped = POS_W'(limit - LIM_W'(1));
      end else begin
         pos_clamped = pixel_position_ff;
      end
      pos_last = (pos_next >= limit);
      pixel_position_in = pixel_position_ff;
      if (req_take) begin
         pixel_position_in = pos_last ? '0 : POS_W'(pos_next);
      end
   end

   // stage 1 registers
   logic                       s1_valid_ff;
   logic [POS_W-1:0]           s1_pos_ff;
   logic [pcsd_pkg::HUE_W-1:0] s1_hue_ff;
   logic                       s1_last_ff;

   // stage 2 registers
   logic                       s2_valid_ff;
   logic [POS_W-1:0]           s2_pos_ff;
   logic [pcsd_pkg::HUE_W-1:0] s2_hue_ff;
   logic                       s2_last_ff;
   logic                       s2_written_ff;

   // fill count and last write-back for forwarding
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic                      lw_valid_ff;
   logic [POS_W-1:0]          lw_pos_ff;
   pcsd_pkg::pixel_state_type lw_data_ff;

   logic [pcsd_pkg::STATE_W-1:0] ram_rd_data;
   logic                         ram_wr_en;
   pcsd_pkg::pixel_state_type    cur_state, new_state;

   assign ram_wr_en = advance && s2_valid_ff;

   pcsd_state_ram #(
      .DEPTH  (MAX_PIXELS),
      .ADDR_W (POS_W),
      .DATA_W (pcsd_pkg::STATE_W)
   ) u_state_ram (
      .clock   (clock),
      .rd_en   (advance && s1_valid_ff),
      .rd_addr (s1_pos_ff),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (s2_pos_ff),
      .wr_data (new_state)
   );

   // stage 2: pick the freshest copy of the pixel state
   always_comb begin
      if (lw_valid_ff && (lw_pos_ff == s2_pos_ff)) begin
         cur_state = lw_data_ff;
      end else if (s2_written_ff) begin
         cur_state = pcsd_pkg::pixel_state_type'(ram_rd_data);
      end else begin
         cur_state = '0;
      end
   end

   // stage 2: sequence update
   logic [pcsd_pkg::PHASE_W-1:0] phase_next_color;
   logic                         hit_cur, hit_next;
   logic [pcsd_pkg::HOLD_W-1:0]  hold_inc;
   logic [pcsd_pkg::MISS_W-1:0]  miss_inc;
   logic [pcsd_pkg::PERIOD_W:0]  period_hi;
   logic                         hold_ok;
   logic [pcsd_pkg::SCORE_W-1:0] score_upd;

   always_comb begin
      phase_next_color = (cur_state.color_state == pcsd_pkg::PHASE_YELLOW) ?
                         pcsd_pkg::PHASE_RED :
                         cur_state.color_state + pcsd_pkg::PHASE_W'(1);
      hit_cur   = pcsd_pkg::hue_in_class(cur_state.color_state, s2_hue_ff);
      hit_next  = pcsd_pkg::hue_in_class(phase_next_color, s2_hue_ff);
      hold_inc  = cur_state.hold_count + pcsd_pkg::HOLD_W'(1);
      miss_inc  = cur_state.miss_count + pcsd_pkg::MISS_W'(1);
      period_hi = {1'b0, period_ff} + (pcsd_pkg::PERIOD_W+1)'(2);
      hold_ok   = ({1'b0, cur_state.hold_count} + (pcsd_pkg::HOLD_W+1)'(2))
                  >= {1'b0, period_ff};

      new_state = cur_state;
      unique case (cur_state.color_state) inside
         pcsd_pkg::PHASE_IDLE: begin
            if (pcsd_pkg::hue_in_class(pcsd_pkg::PHASE_RED, s2_hue_ff)) begin
               new_state.color_state = pcsd_pkg::PHASE_RED;
               new_state.hold_count  = '0;
               new_state.miss_count  = '0;
            end
         end
         pcsd_pkg::PHASE_RED, pcsd_pkg::PHASE_GREEN,
         pcsd_pkg::PHASE_BLUE, pcsd_pkg::PHASE_YELLOW: begin
            if (hit_cur) begin
               new_state.hold_count = hold_inc;
               // held too long
               if ({1'b0, hold_inc} > period_hi) begin
                  new_state.hold_count  = '0;
                  new_state.color_state = pcsd_pkg::PHASE_IDLE;
               end
            end else if (hold_ok && hit_next) begin
               if (cur_state.color_state == pcsd_pkg::PHASE_YELLOW) begin
                  new_state.pixel_score = pcsd_pkg::SCORE_FULL;
               end
               new_state.color_state = phase_next_color;
               new_state.hold_count  = '0;
               new_state.miss_count  = '0;
            end else begin
               new_state.miss_count = miss_inc;
               // second off-color frame drops back to idle
               if (miss_inc > pcsd_pkg::MISS_W'(1)) begin
                  new_state.color_state = pcsd_pkg::PHASE_IDLE;
                  new_state.hold_count  = '0;
               end
            end
         end
         default: begin
            new_state.color_state = pcsd_pkg::PHASE_IDLE;
            new_state.hold_count  = '0;
         end
      endcase

      score_upd = new_state.pixel_score;
      if (score_upd != '0) begin
         score_upd = score_upd - pcsd_pkg::SCORE_W'(1);
      end
      new_state.pixel_score = score_upd;

      fill_in = fill_ff;
      if (ram_wr_en && (CNT_W'(s2_pos_ff) == fill_ff)) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   // output register
   logic [pcsd_pkg::SCORE_W-1:0] rsp_score_ff;
   logic [pcsd_pkg::PHASE_W-1:0] rsp_phase_ff;
   logic                         rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_position_ff <= '0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         fill_ff           <= '0;
         lw_valid_ff       <= 1'b0;
      end else begin
         pixel_position_ff <= pixel_position_in;
         fill_ff           <= fill_in;
         if (advance) begin
            s1_valid_ff  <= req_take;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
         if (ram_wr_en) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pos_ff     <= pos_clamped;
         s1_hue_ff     <= req_tdata;
         s1_last_ff    <= pos_last;
         s2_pos_ff     <= s1_pos_ff;
         s2_hue_ff     <= s1_hue_ff;
         s2_last_ff    <= s1_last_ff;
         s2_written_ff <= (CNT_W'(s1_pos_ff) < fill_ff);
         rsp_score_ff  <= new_state.pixel_score;
         rsp_phase_ff  <= new_state.color_state;
         rsp_last_ff   <= s2_last_ff;
      end
      if (ram_wr_en) begin
         lw_pos_ff  <= s2_pos_ff;
         lw_data_ff <= new_state;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_phase_ff, rsp_score_ff};

endmodule

>>> rtl/pcsd_state_ram.sv
module pcsd_state_ram #(
   parameter int DEPTH  = pcsd_pkg::MAX_PIXELS_DEF,
   parameter int ADDR_W = 19,
   parameter int DATA_W = pcsd_pkg::STATE_W
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-before-write on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/pixel_color_sequence_detector_test.sv
module pixel_color_sequence_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pcsd_pkg::*;

   localparam int MAX_PIX = MAX_PIXELS_DEF;
   localparam int GEN_SLOTS = 16;
   localparam int DRAIN_SLACK = 8;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RSP_HOLD_CYCLES = 400;

   localparam logic [CSR_ADDR_W-1:0] PERIOD_ADDR = {CSR_PERIOD, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] FRAME_ADDR  = {CSR_FRAME_PIXELS, 2'b00};

   typedef struct {
      int unsigned        pixel;
      logic [SCORE_W-1:0] score;
      logic [PHASE_W-1:0] phase;
      logic               frame_end;
   } pixel_result_type;

   // per-pixel sequence tracker and the queue of results it predicts
   class pixel_tracker;
      bit [PHASE_W-1:0] phase_mem [MAX_PIX];
      bit [HOLD_W-1:0]  hold_mem  [MAX_PIX];
      bit [MISS_W-1:0]  miss_mem  [MAX_PIX];
      bit [SCORE_W-1:0] score_mem [MAX_PIX];
      int unsigned      next_pos;
      int unsigned      period_reg;
      int unsigned      frame_reg;
      pixel_result_type expected_q[$];
      int               errors;

      function new();
         next_pos = 0;
         period_reg = PERIOD_RESET;
         frame_reg = FRAME_PIXELS_RESET;
         errors = 0;
      endfunction

      function bit in_color(bit [PHASE_W-1:0] ph, bit [HUE_W-1:0] h);
         case (ph)
            PHASE_RED:    return !(h inside {[HUE_RED_HI : HUE_RED_LO - 8'd1]});
            PHASE_GREEN:  return h inside {[HUE_GREEN_LO : HUE_GREEN_HI - 8'd1]};
            PHASE_BLUE:   return h inside {[HUE_GREEN_HI : HUE_BLUE_HI - 8'd1]};
            PHASE_YELLOW: return h inside {[HUE_YELLOW_LO : HUE_YELLOW_HI - 8'd1]};
            default:      return 1'b0;
         endcase
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_W-1:0] data);
         if (addr[2] == CSR_PERIOD) begin
            period_reg = data[PERIOD_W-1:0];
         end else begin
            frame_reg = data[FRAME_W-1:0];
         end
      endfunction

      function void note_pixel(bit [HUE_W-1:0] hue);
         int unsigned lim, pos, hold, miss, scr;
         bit [PHASE_W-1:0] ph, nxt;
         pixel_result_type res;
         lim = (frame_reg == 0) ? 1 : frame_reg;
         if (lim > MAX_PIX) lim = MAX_PIX;
         pos = (next_pos >= lim) ? lim - 1 : next_pos;
         ph = phase_mem[pos];
         hold = hold_mem[pos];
         miss = miss_mem[pos];
         scr = score_mem[pos];
         if (ph == PHASE_IDLE) begin
            if (in_color(PHASE_RED, hue)) begin
               ph = PHASE_RED;
               hold = 0;
               miss = 0;
            end
         end else if (ph <= PHASE_YELLOW) begin
            nxt = (ph == PHASE_YELLOW) ? PHASE_RED : ph + 3'd1;
            if (in_color(ph, hue)) begin
               hold = (hold + 1) & 8'hFF;
               if (hold > period_reg + 2) begin
                  hold = 0;
                  ph = PHASE_IDLE;
               end
            end else if (hold + 2 >= period_reg && in_color(nxt, hue)) begin
               // closing the cycle on red rearms the score
               if (ph == PHASE_YELLOW) scr = SCORE_FULL;
               ph = nxt;
               hold = 0;
               miss = 0;
            end else begin
               miss = (miss + 1) & 2'h3;
               if (miss > 1) begin
                  ph = PHASE_IDLE;
                  hold = 0;
               end
            end
         end else begin
            ph = PHASE_IDLE;
            hold = 0;
         end
         if (scr > 0) scr = scr - 1;
         phase_mem[pos] = ph;
         hold_mem[pos] = hold[HOLD_W-1:0];
         miss_mem[pos] = miss[MISS_W-1:0];
         score_mem[pos] = scr[SCORE_W-1:0];
         res.pixel = pos;
         res.score = scr[SCORE_W-1:0];
         res.phase = ph;
         res.frame_end = (next_pos + 1 >= lim);
         next_pos = res.frame_end ? 0 : next_pos + 1;
         expected_q.push_back(res);
      endfunction

      function void check_result(logic [SCORE_W-1:0] score, logic [PHASE_W-1:0] phase,
                                 logic frame_end);
         pixel_result_type exp_res;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result score %0d seq_state %0d frame_end %0b",
                     $time, score, phase, frame_end);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (score !== exp_res.score) begin
            $display("%0t: pixel %0d score expected %0d got %0d",
                     $time, exp_res.pixel, exp_res.score, score);
            errors++;
         end
         if (phase !== exp_res.phase) begin
            $display("%0t: pixel %0d seq_state expected %0d got %0d",
                     $time, exp_res.pixel, exp_res.phase, phase);
            errors++;
         end
         if (frame_end !== exp_res.frame_end) begin
            $display("%0t: pixel %0d frame_end expected %0b got %0b",
                     $time, exp_res.pixel, exp_res.frame_end, frame_end);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [7:0]            req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_W-1:0]      csr_pwdata = '0;
   logic [CSR_W-1:0]      csr_prdata;
   logic                  csr_pready;

   pixel_tracker tracker = new();

   bit               steady = 1'b0;
   bit               rsp_hold_request = 1'b0;
   int               noise_pct = 8;
   int unsigned      cur_period = PERIOD_RESET;
   int unsigned      frame_lim = FRAME_PIXELS_RESET;
   int unsigned      gen_pos = 0;
   bit [PHASE_W-1:0] gen_color [GEN_SLOTS];
   int               gen_left  [GEN_SLOTS];
   int               cycle_count = 0;

   pixel_color_sequence_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pixel_color_sequence_detector test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) tracker.note_pixel(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(rsp_tdata[7:0], rsp_tdata[10:8], rsp_tlast);
      end
   end

   function automatic int stall_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 19);
      if (steady || r < 13) return 0;
      if (r < 19) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random back-pressure, plus one long hold-off on request
   initial begin : rsp_side
      forever begin
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else if (steady || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (stall_length()) @(posedge clock);
         end
      end
   end

   task automatic send_pixel(input logic [7:0] hue);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= hue;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      // the monitor notes a transaction taken at the last edge by the next one
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(addr, data);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // return to idle before the next transfer
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned per, input int unsigned fp);
      csr_write(PERIOD_ADDR, per);
      csr_write(FRAME_ADDR, fp);
      cur_period = per;
      frame_lim = (fp == 0) ? 1 : fp;
      if (frame_lim > MAX_PIX) frame_lim = MAX_PIX;
   endtask

   // mirrors the block's position counter; slots are shared by position mod GEN_SLOTS
   function automatic int take_slot();
      int unsigned pos;
      pos = (gen_pos >= frame_lim) ? frame_lim - 1 : gen_pos;
      gen_pos = (gen_pos + 1 >= frame_lim) ? 0 : gen_pos + 1;
      return pos % GEN_SLOTS;
   endfunction

   function automatic logic [7:0] color_hue(input bit [PHASE_W-1:0] color);
      case (color)
         PHASE_RED:
            if ($urandom_range(0, 1) != 0) return 8'($urandom_range(HUE_RED_LO, 255));
            else return 8'($urandom_range(0, HUE_RED_HI - 1));
         PHASE_GREEN:  return 8'($urandom_range(HUE_GREEN_LO, HUE_GREEN_HI - 1));
         PHASE_BLUE:   return 8'($urandom_range(HUE_GREEN_HI, HUE_BLUE_HI - 1));
         default:      return 8'($urandom_range(HUE_YELLOW_LO, HUE_YELLOW_HI - 1));
      endcase
   endfunction

   // each slot walks the color cycle with hold lengths mostly inside the window
   function automatic logic [7:0] next_hue(input int slot);
      if (gen_left[slot] <= 0) begin
         gen_color[slot] = (gen_color[slot] == PHASE_YELLOW) ? PHASE_RED
                                                              : gen_color[slot] + 3'd1;
         if ($urandom_range(0, 99) < 85) begin
            gen_left[slot] = $urandom_range(cur_period + 3,
                                            (cur_period > 1) ? cur_period - 1 : 1);
         end else begin
            gen_left[slot] = $urandom_range(1, cur_period + 6);
         end
      end
      gen_left[slot]--;
      if ($urandom_range(0, 99) < noise_pct) return 8'($urandom_range(0, 255));
      return color_hue(gen_color[slot]);
   endfunction

   task automatic run_phase(input int unsigned per, input int unsigned fp, input int count,
                            input bit calm, input bit hold_rsp, input bit pause_mid,
                            input int noise);
      int slot;
      wait_drained();
      configure(per, fp);
      steady = calm;
      noise_pct = noise;
      if (hold_rsp) rsp_hold_request = 1'b1;
      for (int i = 0; i < count; i++) begin
         slot = take_slot();
         if (frame_lim > 64) send_pixel(8'($urandom_range(0, 255)));
         else send_pixel(next_hue(slot));
         if (pause_mid && i == count / 2) wait_drained();
      end
   endtask

   initial begin : stimulus
      logic [7:0] edge_hues[12];
      // full cycle at period 2, then one tolerated miss and a second that drops to idle
      logic [7:0] cycle_hues[9];
      edge_hues = '{8'd0, 8'd9, 8'd10, 8'd79, 8'd80, 8'd94, 8'd95,
                    8'd124, 8'd125, 8'd149, 8'd150, 8'd255};
      cycle_hues = '{8'd255, 8'd70, 8'd95, 8'd10, 8'd0, 8'd200, 8'd130,
                     8'd160, 8'd130};
      for (int s = 0; s < GEN_SLOTS; s++) begin
         gen_color[s] = PHASE_YELLOW;
         gen_left[s] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // class boundaries at the reset settings, one pixel each
      foreach (edge_hues[i]) begin
         void'(take_slot());
         send_pixel(edge_hues[i]);
      end
      wait_drained();
      configure(2, 1);
      foreach (cycle_hues[i]) begin
         void'(take_slot());
         send_pixel(cycle_hues[i]);
      end

      run_phase(0, 0, 60, 1'b0, 1'b0, 1'b0, 8);
      run_phase(1, 1, 40, 1'b0, 1'b0, 1'b0, 8);
      run_phase(2, 4, 200, 1'b0, 1'b0, 1'b1, 8);
      run_phase(5, 7, 150, 1'b0, 1'b1, 1'b0, 8);
      run_phase(3, 16, 150, 1'b1, 1'b0, 1'b0, 8);
      // long period: the hold counter wraps instead of ending the phase
      run_phase(255, 1, 300, 1'b0, 1'b0, 1'b0, 0);
      run_phase(250, MAX_PIX, 40, 1'b0, 1'b0, 1'b0, 8);
      run_phase(4, 20'hFFFFF, 40, 1'b0, 1'b0, 1'b0, 8);
      // position is far past the new size here, so the first pixel ends a frame
      run_phase(6, 5, 120, 1'b0, 1'b0, 1'b0, 8);
      wait_drained();

      if (tracker.errors == 0) begin
         $display("pixel_color_sequence_detector test passed");
      end else begin
         $display("pixel_color_sequence_detector test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/pcsd_pkg.sv
rtl/pcsd_state_ram.sv
rtl/pixel_color_sequence_detector.sv
tb/sv/pixel_color_sequence_detector_test.sv
